// ===== src/hss_pkg.sv =====
// Shared types and constants for the heat stencil step block.
// Used by heat_stencil_step_top; no dependencies of its own.
package hss_pkg;

  localparam int VALUE_BITS    = 24;
  localparam int MAX_COLS      = 64;
  localparam int MAX_ROWS      = 4096;
  localparam int MIN_SIZE      = 3;
  localparam int COL_BITS      = $clog2(MAX_COLS);
  localparam int ROW_BITS      = $clog2(MAX_ROWS);
  localparam int COLS_CFG_BITS = 7;
  localparam int ROWS_CFG_BITS = 13;
  localparam int WEIGHT_BITS   = 16;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 16;

  // Datapath widths: second differences, weighted products, rounded sum
  localparam int DIFF_BITS  = VALUE_BITS + 2;
  localparam int PROD_BITS  = DIFF_BITS + WEIGHT_BITS + 1;
  localparam int SUM_BITS   = PROD_BITS + 1;
  localparam int FRAC_BITS  = 16;
  localparam int DELTA_BITS = SUM_BITS - FRAC_BITS;
  localparam int UPD_BITS   = DELTA_BITS + 1;

  // Result queue
  localparam int FIFO_DEPTH    = 8;
  localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_BITS = FIFO_PTR_BITS + 1;
  localparam int PEND_BITS     = FIFO_CNT_BITS + 1;

  localparam logic [COLS_CFG_BITS-1:0] COLS_RESET   = COLS_CFG_BITS'(64);
  localparam logic [ROWS_CFG_BITS-1:0] ROWS_RESET   = ROWS_CFG_BITS'(64);
  localparam logic [WEIGHT_BITS-1:0]   WEIGHT_RESET = WEIGHT_BITS'(16384);

  typedef logic signed [VALUE_BITS-1:0]  value_t;
  typedef logic signed [DIFF_BITS-1:0]   diff_t;
  typedef logic signed [WEIGHT_BITS:0]   weight_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [SUM_BITS-1:0]    sum_t;
  typedef logic signed [DELTA_BITS-1:0]  delta_t;
  typedef logic signed [UPD_BITS-1:0]    upd_t;

  localparam sum_t   ROUND_HALF = SUM_BITS'(32'd1 << (FRAC_BITS - 1));
  localparam value_t VALUE_MAX  = {1'b0, {(VALUE_BITS-1){1'b1}}};
  localparam value_t VALUE_MIN  = {1'b1, {(VALUE_BITS-1){1'b0}}};

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_COLS = 2'd0,
    CFG_ROWS = 2'd1,
    CFG_WX   = 2'd2,
    CFG_WY   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic has_first;
    logic interior;
    logic last_row;
    logic last_col;
  } cell_ctl_t;

  typedef struct packed {
    value_t temp;
    logic   run_last;
    logic   frame_end;
  } result_t;

  // Results a cell produces: the delayed row's cell and, on the last row, itself
  function automatic logic [1:0] result_count(cell_ctl_t ctl);
    result_count = {1'b0, ctl.has_first} + {1'b0, ctl.last_row};
  endfunction

endpackage

// ===== src/heat_stencil_step_top.sv =====
// Top level of the heat stencil step: line stores, stencil pipeline, result queue.
// Depends on hss_pkg and hss_ram.
//
// Usage:
//   Grid cells enter row-major on the input channel (in_valid_i / in_stall_o),
//   one cell per request. Results leave on the output channel (out_valid_o /
//   out_stall_i), one row behind the input: while row r arrives, row r-1 is
//   emitted. The first row of a frame gives no results; each cell of the last
//   row gives two (the delayed cell above it, then itself as boundary).
//   Configuration (cfg_valid_i / cfg_ready_o, always ready) sets row length,
//   row count and the two Q0.16 weights; write it only while the block is idle.
// Throughput: one cell per cycle while in_stall_o is low, set by the single read/write
//   pass through the two line-store RAMs; on the last row the output side moves one
//   result per cycle, so in_stall_o holds cells off there as the result queue fills.
// Pipeline: a cell's results pass p1 (RAM read), p2 (differences), p3 (multiply)
//   and p4 (round) before they enter the result queue, visible the next cycle.
// Reset: counters to the start of a frame, registers to their defaults, result
//   queue empty. The line stores are not cleared; the first row fills them.
// Output stall: the 8-entry result queue absorbs results in flight; in_stall_o
//   rises once the queue plus pending results could not take another cell.
module heat_stencil_step_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  hss_pkg::value_t                  cell_in_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output hss_pkg::value_t                  cell_out_o,
  output logic                             run_last_o,
  output logic                             frame_end_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [hss_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [hss_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);
  import hss_pkg::*;

  // Configuration registers
  logic [COLS_CFG_BITS-1:0] cols_q;
  logic [ROWS_CFG_BITS-1:0] rows_q;
  logic [WEIGHT_BITS-1:0]   wx_q;
  logic [WEIGHT_BITS-1:0]   wy_q;

  logic [COL_BITS-1:0] cols_last;
  logic [ROW_BITS-1:0] rows_last;

  logic [COL_BITS-1:0] col_count_q, col_count_d;
  logic [ROW_BITS-1:0] row_count_q, row_count_d;
  logic [COL_BITS-1:0] next_col;
  cell_ctl_t           cur_ctl;
  logic                in_acc;

  // Line-store data and neighbor registers
  value_t newer_rd;
  value_t older_rd;
  value_t center_q;
  value_t left_q;

  // Pipeline stages
  logic                p1_valid_q, p2_valid_q, p3_valid_q, p4_valid_q;
  logic [COL_BITS-1:0] p1_col_q;
  value_t              p1_cell_q, p2_cell_q, p3_cell_q, p4_cell_q;
  cell_ctl_t           p1_ctl_q, p2_ctl_q, p3_ctl_q, p4_ctl_q;
  value_t              p2_center_q, p3_center_q, p4_center_q;
  diff_t               p2_dx_q, p2_dy_q;
  prod_t               p3_px_q, p3_py_q;
  delta_t              p4_delta_q;

  diff_t   diff_x, diff_y;
  weight_t wx_s, wy_s;
  prod_t   prod_x, prod_y;
  sum_t    prod_sum;
  upd_t    upd_sum;
  value_t  upd_sat;
  value_t  stencil_val;

  // Result queue
  result_t                  fifo_q [FIFO_DEPTH];
  logic [FIFO_PTR_BITS-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_BITS-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_BITS-1:0] fifo_cnt_q, fifo_cnt_d;
  logic [1:0]               push_n;
  logic                     pop;
  result_t                  res0, res1;
  result_t                  head;
  logic [PEND_BITS-1:0]     pending;

  // ---------------------------------------------------------------------------
  // Configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
      wx_q   <= WEIGHT_RESET;
      wy_q   <= WEIGHT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COLS: cols_q <= cfg_data_i[COLS_CFG_BITS-1:0];
        CFG_ROWS: rows_q <= cfg_data_i[ROWS_CFG_BITS-1:0];
        CFG_WX:   wx_q   <= cfg_data_i[WEIGHT_BITS-1:0];
        CFG_WY:   wy_q   <= cfg_data_i[WEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the frame size and keep the last valid index
  always_comb begin
    if (cols_q < COLS_CFG_BITS'(MIN_SIZE)) begin
      cols_last = COL_BITS'(MIN_SIZE - 1);
    end else if (cols_q > COLS_CFG_BITS'(MAX_COLS)) begin
      cols_last = COL_BITS'(MAX_COLS - 1);
    end else begin
      cols_last = COL_BITS'(cols_q - COLS_CFG_BITS'(1));
    end
    if (rows_q < ROWS_CFG_BITS'(MIN_SIZE)) begin
      rows_last = ROW_BITS'(MIN_SIZE - 1);
    end else if (rows_q > ROWS_CFG_BITS'(MAX_ROWS)) begin
      rows_last = ROW_BITS'(MAX_ROWS - 1);
    end else begin
      rows_last = ROW_BITS'(rows_q - ROWS_CFG_BITS'(1));
    end
  end

  // ---------------------------------------------------------------------------
  // Position counters and request acceptance
  assign in_acc = in_valid_i && !in_stall_o;

  always_comb begin
    cur_ctl.last_col  = col_count_q >= cols_last;
    cur_ctl.last_row  = row_count_q >= rows_last;
    cur_ctl.has_first = row_count_q != '0;
    cur_ctl.interior  = (row_count_q >= ROW_BITS'(2)) && (col_count_q != '0)
                        && !cur_ctl.last_col;
    next_col = cur_ctl.last_col ? '0 : col_count_q + COL_BITS'(1);

    col_count_d = col_count_q;
    row_count_d = row_count_q;
    if (in_acc) begin
      col_count_d = next_col;
      if (cur_ctl.last_col) begin
        row_count_d = cur_ctl.last_row ? '0 : row_count_q + ROW_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_count_q <= '0;
      row_count_q <= '0;
    end else begin
      col_count_q <= col_count_d;
      row_count_q <= row_count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Line stores. The newer row is read one column ahead: that word is the
  // right neighbor now and becomes the center for the next cell.
  hss_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_COLS)
  ) u_newer_ram (
    .clk_i   (clk_i),
    .we_i    (p1_valid_q),
    .waddr_i (p1_col_q),
    .wdata_i (p1_cell_q),
    .re_i    (in_acc),
    .raddr_i (next_col),
    .rdata_o (newer_rd)
  );

  hss_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (MAX_COLS)
  ) u_older_ram (
    .clk_i   (clk_i),
    .we_i    (p1_valid_q),
    .waddr_i (p1_col_q),
    .wdata_i (center_q),
    .re_i    (in_acc),
    .raddr_i (col_count_q),
    .rdata_o (older_rd)
  );

  // ---------------------------------------------------------------------------
  // Stencil pipeline: differences, weighted products, rounding, saturation
  always_comb begin
    diff_x = DIFF_BITS'(newer_rd) - (DIFF_BITS'(center_q) <<< 1) + DIFF_BITS'(left_q);
    diff_y = DIFF_BITS'(older_rd) - (DIFF_BITS'(center_q) <<< 1) + DIFF_BITS'(p1_cell_q);
    wx_s   = weight_t'({1'b0, wx_q});
    wy_s   = weight_t'({1'b0, wy_q});
    prod_x = PROD_BITS'(wx_s) * PROD_BITS'(p2_dx_q);
    prod_y = PROD_BITS'(wy_s) * PROD_BITS'(p2_dy_q);
    prod_sum = SUM_BITS'(p3_px_q) + SUM_BITS'(p3_py_q) + ROUND_HALF;
    upd_sum  = UPD_BITS'(p4_center_q) + UPD_BITS'(p4_delta_q);
    if (upd_sum > UPD_BITS'(VALUE_MAX)) begin
      upd_sat = VALUE_MAX;
    end else if (upd_sum < UPD_BITS'(VALUE_MIN)) begin
      upd_sat = VALUE_MIN;
    end else begin
      upd_sat = VALUE_BITS'(upd_sum);
    end
    stencil_val = p4_ctl_q.interior ? upd_sat : p4_center_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      p4_valid_q <= 1'b0;
      center_q   <= '0;
      left_q     <= '0;
    end else begin
      p1_valid_q <= in_acc;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
      p4_valid_q <= p3_valid_q;
      if (p1_valid_q) begin
        center_q <= newer_rd;
        left_q   <= center_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p1_col_q  <= col_count_q;
      p1_cell_q <= cell_in_i;
      p1_ctl_q  <= cur_ctl;
    end
    if (p1_valid_q) begin
      p2_dx_q     <= diff_x;
      p2_dy_q     <= diff_y;
      p2_center_q <= center_q;
      p2_cell_q   <= p1_cell_q;
      p2_ctl_q    <= p1_ctl_q;
    end
    if (p2_valid_q) begin
      p3_px_q     <= prod_x;
      p3_py_q     <= prod_y;
      p3_center_q <= p2_center_q;
      p3_cell_q   <= p2_cell_q;
      p3_ctl_q    <= p2_ctl_q;
    end
    if (p3_valid_q) begin
      p4_delta_q  <= prod_sum[SUM_BITS-1:FRAC_BITS];
      p4_center_q <= p3_center_q;
      p4_cell_q   <= p3_cell_q;
      p4_ctl_q    <= p3_ctl_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Result queue: up to two pushes per cycle, one pop
  always_comb begin
    res0.temp      = stencil_val;
    res0.run_last  = !p4_ctl_q.last_row;
    res0.frame_end = 1'b0;
    res1.temp      = p4_cell_q;
    res1.run_last  = 1'b1;
    res1.frame_end = p4_ctl_q.last_col;
    // Without a delayed cell the boundary result goes first
    if (!p4_ctl_q.has_first) begin
      res0 = res1;
    end
    push_n = p4_valid_q ? result_count(p4_ctl_q) : 2'd0;
    pop    = out_valid_o && !out_stall_i;

    wr_ptr_d   = wr_ptr_q + FIFO_PTR_BITS'(push_n);
    rd_ptr_d   = rd_ptr_q + FIFO_PTR_BITS'(pop);
    fifo_cnt_d = fifo_cnt_q + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(pop);

    pending = PEND_BITS'(fifo_cnt_q)
            + (p1_valid_q ? PEND_BITS'(result_count(p1_ctl_q)) : '0)
            + (p2_valid_q ? PEND_BITS'(result_count(p2_ctl_q)) : '0)
            + (p3_valid_q ? PEND_BITS'(result_count(p3_ctl_q)) : '0)
            + PEND_BITS'(push_n);
  end

  // Hold requests off while a new cell's results might not fit
  assign in_stall_o = pending > PEND_BITS'(FIFO_DEPTH - 2);

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[wr_ptr_q + FIFO_PTR_BITS'(1)] <= res1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fifo_cnt_q <= '0;
    end else begin
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      fifo_cnt_q <= fifo_cnt_d;
    end
  end

  assign head        = fifo_q[rd_ptr_q];
  assign out_valid_o = fifo_cnt_q != '0;
  assign cell_out_o  = head.temp;
  assign run_last_o  = head.run_last;
  assign frame_end_o = head.frame_end;

`ifndef NO_ASSERTIONS
  a_fifo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_cnt_q <= FIFO_CNT_BITS'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_pipe_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> p1_valid_q ##1 p2_valid_q ##1 p3_valid_q ##1 p4_valid_q)
    else $error("cell lost in stencil pipeline");

  a_no_ram_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (p1_valid_q && in_acc) |-> (next_col != p1_col_q && col_count_q != p1_col_q))
    else $error("line store read and write hit the same column");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n != 2'd0) |-> (fifo_cnt_q + FIFO_CNT_BITS'(push_n)
                          <= FIFO_CNT_BITS'(FIFO_DEPTH)))
    else $error("result push without room");
`endif

endmodule

// ===== src/hss_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module hss_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== bench/heat_stencil_step_top_test.sv =====
`timescale 1ns / 1ps
// Testbench for heat_stencil_step_top: streams grid frames through the stencil and checks every
// result against an in-bench Jacobi-step predictor. Depends on hss_pkg and the block's RTL.
module heat_stencil_step_top_test;
  import hss_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_CELLS = 1400;
  localparam int MAX_SHOWN    = 10;

  // Predicts the stepped grid and holds the results still owed by the block
  class stencil_scoreboard;
    int unsigned cols_cfg, rows_cfg;
    longint      weight_x, weight_y;
    value_t      older_line[MAX_COLS];
    value_t      newer_line[MAX_COLS];
    int unsigned col_pos, row_pos;
    value_t      left_cell;
    result_t     expected_cells[$];
    int unsigned mismatches, checked, cells_seen, reg_writes;

    function new();
      cols_cfg = COLS_RESET;
      rows_cfg = ROWS_RESET;
      weight_x = WEIGHT_RESET;
      weight_y = WEIGHT_RESET;
      foreach (older_line[i]) begin
        older_line[i] = '0;
        newer_line[i] = '0;
      end
      col_pos = 0;
      row_pos = 0;
      left_cell = '0;
      mismatches = 0;
      checked = 0;
      cells_seen = 0;
      reg_writes = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        CFG_COLS: cols_cfg = data[COLS_CFG_BITS-1:0];
        CFG_ROWS: rows_cfg = data[ROWS_CFG_BITS-1:0];
        CFG_WX:   weight_x = data[WEIGHT_BITS-1:0];
        CFG_WY:   weight_y = data[WEIGHT_BITS-1:0];
        default: ;
      endcase
      reg_writes++;
    endfunction

    function int unsigned clamp_size(int unsigned v, int unsigned hi);
      if (v < MIN_SIZE) return MIN_SIZE;
      if (v > hi) return hi;
      return v;
    endfunction

    function int unsigned cols_eff();
      return clamp_size(cols_cfg, MAX_COLS);
    endfunction

    function bit at_frame_start();
      return col_pos == 0 && row_pos == 0;
    endfunction

    // Five-point update, product sum rounded half up from Q.16 to Q.0, then saturated
    function value_t diffuse(value_t mid, value_t west, value_t east, value_t north,
                             value_t south);
      longint dx, dy, acc, sum;
      dx  = longint'(east) - 2 * longint'(mid) + longint'(west);
      dy  = longint'(north) - 2 * longint'(mid) + longint'(south);
      acc = weight_x * dx + weight_y * dy + 32768;
      sum = longint'(mid) + (acc >>> 16);
      if (sum > longint'(VALUE_MAX)) return VALUE_MAX;
      if (sum < longint'(VALUE_MIN)) return VALUE_MIN;
      return value_t'(sum);
    endfunction

    function void note_cell(value_t x);
      int unsigned cols, rows, c, r;
      bit          last_col, last_row;
      result_t     res;
      cols = cols_eff();
      rows = clamp_size(rows_cfg, MAX_ROWS);
      c = col_pos % MAX_COLS;
      r = row_pos;
      last_col = c >= cols - 1;
      last_row = r >= rows - 1;
      if (r >= 1) begin
        res.temp = newer_line[c];
        if (r >= 2 && c != 0 && !last_col)
          res.temp = diffuse(newer_line[c], left_cell, newer_line[(c + 1) % MAX_COLS],
                             older_line[c], x);
        res.run_last = !last_row;
        res.frame_end = 1'b0;
        expected_cells.push_back(res);
      end
      // the last row also leaves as its own boundary
      if (last_row) begin
        res.temp = x;
        res.run_last = 1'b1;
        res.frame_end = last_col;
        expected_cells.push_back(res);
      end
      older_line[c] = newer_line[c];
      left_cell = newer_line[c];
      newer_line[c] = x;
      if (last_col) begin
        col_pos = 0;
        row_pos = last_row ? 0 : r + 1;
      end else begin
        col_pos = c + 1;
      end
      cells_seen++;
    endfunction

    function void check_result(value_t temp, logic run_last, logic frame_end);
      result_t want;
      if (expected_cells.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("unexpected result: cell %0d run_last %0b frame_end %0b",
                   temp, run_last, frame_end);
        return;
      end
      want = expected_cells.pop_front();
      checked++;
      if (want.temp !== temp || want.run_last !== run_last || want.frame_end !== frame_end)
          begin
        mismatches++;
        if (mismatches <= MAX_SHOWN)
          $display("result %0d: expected cell %0d run_last %0b frame_end %0b, got %0d %0b %0b",
                   checked, want.temp, want.run_last, want.frame_end, temp, run_last,
                   frame_end);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i, in_stall_o;
  value_t cell_in_i;
  logic out_valid_o, out_stall_i;
  value_t cell_out_o;
  logic run_last_o, frame_end_o;
  logic cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [CFG_DATA_BITS-1:0] cfg_data_i;

  stencil_scoreboard sb = new();
  bit no_idle = 1'b0;

  heat_stencil_step_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cell_in_i   (cell_in_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cell_out_o  (cell_out_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      sb.check_result(cell_out_o, run_last_o, frame_end_o);
  end

  // Called at a falling edge; returns at the falling edge after the request is taken
  task automatic send_cell(value_t v);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cell_in_i <= v;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_cell(v);
    @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.write_reg(idx, data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // Hold the sender until every owed result is out and the pipeline is empty
  task automatic settle_block();
    in_valid_i <= 1'b0;
    while (sb.expected_cells.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  function automatic value_t pick_cell(int unsigned style);
    value_t v;
    case (style)
      0: begin
        case ($urandom_range(0, 3))
          0: v = VALUE_MAX;
          1: v = VALUE_MIN;
          default: v = value_t'($urandom);
        endcase
      end
      1: v = value_t'($urandom);
      default: v = value_t'(int'($urandom_range(0, 8191)) - 4096);
    endcase
    return v;
  endfunction

  task automatic feed_frame(int unsigned style, bit tall);
    int unsigned cut;
    if (tall) begin
      // run a few rows of a tall frame, then shorten it mid-frame
      cut = $urandom_range(2, 5) * sb.cols_eff() + $urandom_range(0, sb.cols_eff() - 1);
      repeat (cut) send_cell(pick_cell(style));
      settle_block();
      write_reg(CFG_ROWS, 16'($urandom_range(0, 5)) | 16'($urandom & 32'hE000));
    end
    do send_cell(pick_cell(style)); while (!sb.at_frame_start());
  endtask

  task automatic random_phase();
    int unsigned cols, rows, frames;
    bit tall;
    logic [WEIGHT_BITS-1:0] w;
    no_idle = ($urandom_range(0, 4) == 0);
    case ($urandom_range(0, 9))
      0: cols = $urandom_range(0, 2);
      1: cols = $urandom_range(65, 127);
      2: cols = MAX_COLS;
      default: cols = $urandom_range(3, 12);
    endcase
    tall = 1'b0;
    case ($urandom_range(0, 9))
      0: rows = $urandom_range(0, 2);
      1: begin
        rows = $urandom_range(100, 8191);
        tall = 1'b1;
      end
      default: rows = $urandom_range(3, 6);
    endcase
    write_reg(CFG_COLS, 16'(cols) | 16'($urandom & 32'hFF80));
    write_reg(CFG_ROWS, 16'(rows) | 16'($urandom & 32'hE000));
    for (int i = 0; i < 2; i++) begin
      case ($urandom_range(0, 5))
        0: w = '0;
        1: w = '1;
        default: w = WEIGHT_BITS'($urandom);
      endcase
      write_reg(i == 0 ? CFG_WX : CFG_WY, w);
    end
    frames = $urandom_range(1, 3);
    for (int f = 0; f < frames; f++)
      feed_frame($urandom_range(0, 3), tall && f == 0);
    settle_block();
  endtask

  initial begin
    out_stall_i = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      int unsigned hold;
      hold = no_idle ? 0 : $urandom_range(0, 17);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      @(negedge clk_i);
    end
  end

  initial begin
    int unsigned first_random;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    cell_in_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_COLS;
    cfg_data_i = '0;
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // smallest frame, full weights: interior cell saturates high
    write_reg(CFG_COLS, 16'd3);
    write_reg(CFG_ROWS, 16'd3);
    write_reg(CFG_WX, 16'hFFFF);
    write_reg(CFG_WY, 16'hFFFF);
    send_cell(VALUE_MIN); send_cell(VALUE_MAX); send_cell(value_t'(0));
    send_cell(VALUE_MAX); send_cell(VALUE_MIN); send_cell(VALUE_MAX);
    send_cell(value_t'(1)); send_cell(VALUE_MAX); send_cell(value_t'(-1));
    settle_block();

    // sizes below and above range clamp; rows cut mid-frame; interior saturates low
    write_reg(CFG_COLS, 16'hFF80);
    write_reg(CFG_ROWS, 16'hFFFF);
    write_reg(CFG_WX, 16'h0000);
    write_reg(CFG_WY, 16'hFFFF);
    send_cell(value_t'(0)); send_cell(VALUE_MIN); send_cell(value_t'(7));
    send_cell(value_t'(-1)); send_cell(VALUE_MAX); send_cell(value_t'(256));
    settle_block();
    write_reg(CFG_ROWS, 16'd2);
    send_cell(value_t'(3)); send_cell(VALUE_MIN); send_cell(VALUE_MAX);
    settle_block();

    // widest rows and the row ceiling, then narrow the row while inside it
    write_reg(CFG_COLS, 16'(MAX_COLS));
    write_reg(CFG_ROWS, 16'(MAX_ROWS));
    write_reg(CFG_WX, 16'd16384);
    write_reg(CFG_WY, 16'd8192);
    repeat (3 * MAX_COLS + 40) send_cell(pick_cell(2));
    settle_block();
    write_reg(CFG_COLS, 16'd5);
    write_reg(CFG_ROWS, 16'd6);
    do send_cell(pick_cell(1)); while (!sb.at_frame_start());
    settle_block();

    first_random = sb.cells_seen;
    while (sb.cells_seen - first_random < RANDOM_CELLS) random_phase();

    settle_block();
    $display("ran %0d cells through %0d register writes; %0d results checked, %0d mismatches",
             sb.cells_seen, sb.reg_writes, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_cells.size() == 0) begin
      $display("heat_stencil_step_top test passed");
    end else begin
      $display("heat_stencil_step_top test failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timed out with %0d results outstanding", sb.expected_cells.size());
    $display("heat_stencil_step_top test failed");
    $finish;
  end

endmodule

// ===== heat_stencil_step_top.f =====
src/hss_pkg.sv
src/hss_ram.sv
src/heat_stencil_step_top.sv
bench/heat_stencil_step_top_test.sv
